>>> rtl/mrde_pkg.sv
// Shared types and constants for the mini RISC decode and execute block.
package mrde_pkg;

    // Fixed field widths.
    localparam int PC_W     = 12;
    localparam int REG_AW   = 3;
    localparam int NUM_REGS = 8;
    localparam int LOAD_W   = 32;

    // Item modes.
    localparam logic [1:0] MODE_EXEC     = 2'd0;
    localparam logic [1:0] MODE_LOAD_REG = 2'd1;
    localparam logic [1:0] MODE_LOAD_MEM = 2'd2;

    // Opcodes and the funct code of ADD.
    localparam logic [3:0] OPC_RTYPE = 4'd0;
    localparam logic [3:0] OPC_J     = 4'd2;
    localparam logic [3:0] OPC_JAL   = 4'd3;
    localparam logic [3:0] OPC_LW    = 4'd4;
    localparam logic [3:0] OPC_SW    = 4'd5;
    localparam logic [2:0] FUNCT_ADD = 3'd0;

    // Reported operation kinds.
    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_LOAD    = 3'd1;
    localparam logic [2:0] KIND_STORE   = 3'd2;
    localparam logic [2:0] KIND_JUMP    = 3'd3;
    localparam logic [2:0] KIND_NOP     = 3'd4;
    localparam logic [2:0] KIND_PRELOAD = 3'd5;

    // Input transaction.
    typedef struct packed {
        logic [1:0]        mode;
        logic [15:0]       instr_word;
        logic [7:0]        load_index;
        logic [LOAD_W-1:0] load_value;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic [2:0]        op_kind;
        logic [PC_W-1:0]   next_pc;
        logic              finished;
        logic              reg_wrote;
        logic [REG_AW-1:0] dest_reg;
        logic [31:0]       dest_value;
        logic              mem_wrote;
        logic [7:0]        mem_addr;
    } out_t;

    // Register file write port control.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
    } rf_wr_t;

    // Side effects decided by the execute logic.
    typedef struct packed {
        logic pc_we;
        logic is_lw;
        logic mem_we;
        logic mem_re;
    } ex_ctl_t;

endpackage

>>> rtl/mrde_regfile.sv
// Register file with registered operand reads and write forwarding.
module mrde_regfile #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mrde_pkg::rf_wr_t                wr,
    input  logic [WORD_WIDTH-1:0]           wr_data,
    input  mrde_pkg::rf_wr_t                byp,
    input  logic [WORD_WIDTH-1:0]           byp_data,
    input  logic                            load,
    input  logic [mrde_pkg::REG_AW-1:0]     rd_addr_a,
    input  logic [mrde_pkg::REG_AW-1:0]     rd_addr_b,
    output logic [WORD_WIDTH-1:0]           op_a,
    output logic [WORD_WIDTH-1:0]           op_b
);

    logic [WORD_WIDTH-1:0]       rf_reg [mrde_pkg::NUM_REGS];
    logic [WORD_WIDTH-1:0]       op_a_reg;
    logic [WORD_WIDTH-1:0]       op_b_reg;
    logic [WORD_WIDTH-1:0]       op_a_next;
    logic [WORD_WIDTH-1:0]       op_b_next;
    logic [mrde_pkg::REG_AW-1:0] addr_a_reg;
    logic [mrde_pkg::REG_AW-1:0] addr_b_reg;

    // A pending write-back is not yet in the array, so it overrides the held operand.
    assign op_a = (wr.en && wr.addr == addr_a_reg) ? wr_data : op_a_reg;
    assign op_b = (wr.en && wr.addr == addr_b_reg) ? wr_data : op_b_reg;

    // New operands see the leaving instruction first, then the write-back, then the array.
    always_comb
    begin
        if (load)
        begin
            if (byp.en && byp.addr == rd_addr_a)
                op_a_next = byp_data;
            else if (wr.en && wr.addr == rd_addr_a)
                op_a_next = wr_data;
            else
                op_a_next = rf_reg[rd_addr_a];
            if (byp.en && byp.addr == rd_addr_b)
                op_b_next = byp_data;
            else if (wr.en && wr.addr == rd_addr_b)
                op_b_next = wr_data;
            else
                op_b_next = rf_reg[rd_addr_b];
        end
        else
        begin
            op_a_next = op_a;
            op_b_next = op_b;
        end
    end

    // Register array, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mrde_pkg::NUM_REGS; i++)
                rf_reg[i] <= '0;
        end
        else if (wr.en)
        begin
            rf_reg[wr.addr] <= wr_data;
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        if (load)
        begin
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

endmodule

>>> rtl/mrde_data_mem.sv
// Data memory with one write port, one registered read port and a clearing pass.
module mrde_data_mem #(
    parameter int DATA_DEPTH = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(DATA_DEPTH)-1:0] wr_addr,
    input  logic [WORD_WIDTH-1:0]         wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DATA_DEPTH)-1:0] rd_addr,
    output logic [WORD_WIDTH-1:0]         rd_data,
    output logic                          busy
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);

    logic [WORD_WIDTH-1:0] mem [DATA_DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  busy_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [WORD_WIDTH-1:0] wdata;

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;

    // The clearing pass owns the write port until it completes.
    always_comb
    begin
        if (busy_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = wr_en;
            waddr = wr_addr;
            wdata = wr_data;
        end
    end

    // Clearing pass sequencer, one word per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DATA_DEPTH - 1))
                busy_reg <= 1'b0;
        end
    end

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/mrde_exec.sv
// Instruction decode and execute logic for the instruction in the input register.
module mrde_exec #(
    parameter int DATA_DEPTH = 256,
    parameter int WORD_WIDTH = 32
) (
    input  mrde_pkg::in_t                   item,
    input  logic [mrde_pkg::PC_W-1:0]       pc,
    input  logic [mrde_pkg::PC_W-1:0]       prog_len,
    input  logic [WORD_WIDTH-1:0]           op_rs,
    input  logic [WORD_WIDTH-1:0]           op_rt,
    output mrde_pkg::out_t                  result,
    output mrde_pkg::ex_ctl_t               ctl,
    output logic [WORD_WIDTH-1:0]           wdata,
    output logic [$clog2(DATA_DEPTH)-1:0]   maddr
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);
    localparam int XW0    = (WORD_WIDTH > ADDR_W) ? WORD_WIDTH : ADDR_W;
    localparam int XW     = (XW0 > 8) ? XW0 : 8;

    logic [3:0]                  opc;
    logic [mrde_pkg::REG_AW-1:0] rs_f;
    logic [mrde_pkg::REG_AW-1:0] rt_f;
    logic [mrde_pkg::REG_AW-1:0] rd_f;
    logic [2:0]                  funct;
    logic [5:0]                  imm;
    logic [XW-1:0]               ea_sum;
    logic [XW-1:0]               li_ext;
    logic                        running;
    logic                        jump;
    logic [mrde_pkg::PC_W-1:0]   npc;

    assign opc   = item.instr_word[15:12];
    assign rs_f  = item.instr_word[11:9];
    assign rt_f  = item.instr_word[8:6];
    assign rd_f  = item.instr_word[5:3];
    assign funct = item.instr_word[2:0];
    assign imm   = item.instr_word[5:0];

    // Effective address (base plus unsigned offset) and preload address, both wrapped.
    assign ea_sum  = XW'(op_rs) + XW'(imm);
    assign li_ext  = XW'(item.load_index);
    assign running = (item.mode == mrde_pkg::MODE_EXEC) && (pc < prog_len);

    // Decode and execute.
    always_comb
    begin
        result.op_kind   = mrde_pkg::KIND_NOP;
        result.reg_wrote = 1'b0;
        result.dest_reg  = '0;
        result.mem_wrote = 1'b0;
        ctl              = '0;
        wdata            = '0;
        maddr            = '0;
        jump             = 1'b0;
        npc              = pc;

        unique case (item.mode)
            mrde_pkg::MODE_LOAD_REG:
            begin
                result.op_kind   = mrde_pkg::KIND_PRELOAD;
                result.reg_wrote = 1'b1;
                result.dest_reg  = item.load_index[mrde_pkg::REG_AW-1:0];
                wdata            = WORD_WIDTH'(item.load_value);
            end
            mrde_pkg::MODE_LOAD_MEM:
            begin
                result.op_kind   = mrde_pkg::KIND_PRELOAD;
                result.mem_wrote = 1'b1;
                ctl.mem_we       = 1'b1;
                maddr            = li_ext[ADDR_W-1:0];
                wdata            = WORD_WIDTH'(item.load_value);
            end
            mrde_pkg::MODE_EXEC:
            begin
                if (running)
                begin
                    unique case (opc) inside
                        mrde_pkg::OPC_RTYPE:
                        begin
                            if (funct == mrde_pkg::FUNCT_ADD)
                            begin
                                result.op_kind   = mrde_pkg::KIND_ADD;
                                result.reg_wrote = 1'b1;
                                result.dest_reg  = rd_f;
                                wdata            = op_rs + op_rt;
                            end
                        end
                        mrde_pkg::OPC_J, mrde_pkg::OPC_JAL:
                        begin
                            result.op_kind = mrde_pkg::KIND_JUMP;
                            jump           = 1'b1;
                        end
                        mrde_pkg::OPC_LW:
                        begin
                            result.op_kind   = mrde_pkg::KIND_LOAD;
                            result.reg_wrote = 1'b1;
                            result.dest_reg  = rt_f;
                            ctl.is_lw        = 1'b1;
                            ctl.mem_re       = 1'b1;
                            maddr            = ea_sum[ADDR_W-1:0];
                        end
                        mrde_pkg::OPC_SW:
                        begin
                            result.op_kind   = mrde_pkg::KIND_STORE;
                            result.mem_wrote = 1'b1;
                            ctl.mem_we       = 1'b1;
                            maddr            = ea_sum[ADDR_W-1:0];
                            wdata            = op_rt;
                        end
                        default:
                        begin
                            result.op_kind = mrde_pkg::KIND_NOP;
                        end
                    endcase
                    ctl.pc_we = 1'b1;
                    npc = jump ? item.instr_word[mrde_pkg::PC_W-1:0] : pc + 1'b1;
                end
            end
            default:
            begin
                result.op_kind = mrde_pkg::KIND_NOP;
            end
        endcase

        result.next_pc    = npc;
        result.finished   = (npc >= prog_len);
        result.dest_value = 32'(wdata);
        result.mem_addr   = 8'(maddr);
    end

endmodule

>>> rtl/mini_risc_decode_execute.sv
// Top level of the mini RISC decode and execute block. It runs one 16-bit
// instruction or one preload transaction per clock unless held by the result
// stall or the memory clearing pass: a transaction is accepted into the input
// register, where the register operands arrive already read, and is decoded
// and executed there; its result moves to the result register once that
// register is free, and a new transaction can be accepted in the same cycle.
// A result is valid once its transaction reaches the result register. Loads
// finish in the result stage from the data memory's registered read port, and
// register values are forwarded so that dependent instructions still issue
// back to back. After reset the data memory is cleared one word per cycle, so
// no transaction is accepted until the clearing pass completes; configuration
// writes are taken throughout. DATA_DEPTH must be a power of two.
module mini_risc_decode_execute #(
    parameter int DATA_DEPTH = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      instr_valid,
    output logic                      instr_stall,
    input  mrde_pkg::in_t             instr_data,
    output logic                      result_valid,
    input  logic                      result_stall,
    output mrde_pkg::out_t            result_data,
    input  logic                      cfg_wr_en,
    input  logic [mrde_pkg::PC_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);

    logic                      s1_valid_reg;
    mrde_pkg::in_t             s1_item_reg;
    logic                      s2_valid_reg;
    mrde_pkg::out_t            s2_out_reg;
    logic                      s2_lw_reg;
    logic                      wb_pending_reg;
    logic [WORD_WIDTH-1:0]     wb_data_reg;
    logic [mrde_pkg::PC_W-1:0] pc_reg;
    logic [mrde_pkg::PC_W-1:0] prog_len_reg;

    logic                      s2_free;
    logic                      s1_adv;
    logic                      accept;
    logic                      mem_busy;
    logic [WORD_WIDTH-1:0]     mem_rdata;
    logic [WORD_WIDTH-1:0]     op_rs;
    logic [WORD_WIDTH-1:0]     op_rt;
    logic [WORD_WIDTH-1:0]     ex_wdata;
    logic [ADDR_W-1:0]         ex_maddr;
    mrde_pkg::out_t            ex_out;
    mrde_pkg::ex_ctl_t         ex_ctl;
    mrde_pkg::rf_wr_t          wb;
    logic [WORD_WIDTH-1:0]     wb_data;
    mrde_pkg::rf_wr_t          byp;

    // Handshake: the input register moves on whenever the result register is free.
    assign s2_free     = !s2_valid_reg || !result_stall;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign instr_stall = mem_busy || (s1_valid_reg && !s2_free);
    assign accept      = instr_valid && !instr_stall;

    // Register write-back happens in the first cycle of the result stage.
    assign wb.en    = wb_pending_reg;
    assign wb.addr  = s2_out_reg.dest_reg;
    assign wb_data  = s2_lw_reg ? mem_rdata : wb_data_reg;

    // A leaving instruction whose value is already known feeds the next operand read.
    assign byp.en   = s1_adv && ex_out.reg_wrote && !ex_ctl.is_lw;
    assign byp.addr = ex_out.dest_reg;

    mrde_regfile #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wb),
        .wr_data   (wb_data),
        .byp       (byp),
        .byp_data  (ex_wdata),
        .load      (accept),
        .rd_addr_a (instr_data.instr_word[11:9]),
        .rd_addr_b (instr_data.instr_word[8:6]),
        .op_a      (op_rs),
        .op_b      (op_rt)
    );

    mrde_exec #(
        .DATA_DEPTH (DATA_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_exec (
        .item     (s1_item_reg),
        .pc       (pc_reg),
        .prog_len (prog_len_reg),
        .op_rs    (op_rs),
        .op_rt    (op_rt),
        .result   (ex_out),
        .ctl      (ex_ctl),
        .wdata    (ex_wdata),
        .maddr    (ex_maddr)
    );

    mrde_data_mem #(
        .DATA_DEPTH (DATA_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_data_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv && ex_ctl.mem_we),
        .wr_addr (ex_maddr),
        .wr_data (ex_wdata),
        .rd_en   (s1_adv && ex_ctl.mem_re),
        .rd_addr (ex_maddr),
        .rd_data (mem_rdata),
        .busy    (mem_busy)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= instr_data;
    end

    // Program counter and program length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            prog_len_reg <= '0;
        end
        else
        begin
            if (s1_adv && ex_ctl.pc_we)
                pc_reg <= ex_out.next_pc;
            if (cfg_wr_en)
                prog_len_reg <= cfg_wr_data;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            wb_pending_reg <= 1'b0;
        end
        else
        begin
            wb_pending_reg <= s1_adv && ex_out.reg_wrote;
            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (!result_stall)
                s2_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_out_reg  <= ex_out;
            s2_lw_reg   <= ex_ctl.is_lw;
            wb_data_reg <= ex_wdata;
        end
    end

    // A load takes its value from the memory read register.
    always_comb
    begin
        result_data = s2_out_reg;
        if (s2_lw_reg)
            result_data.dest_value = 32'(mem_rdata);
    end

    assign result_valid = s2_valid_reg;

endmodule
